### rtl/core/fhbt_pkg.sv
// Shared types and constants for the hashed bucket table unit.
// Holds the command codes, the controller state type and the control and
// status structs that join the controller to the datapath. No dependencies.
package fhbt_pkg;

  // Fixed field widths of the command and result ports, and of the hash.
  localparam int CMD_W   = 2;
  localparam int BYTE_W  = 8;
  localparam int NV_W    = 32;
  localparam int FOUND_W = 32;
  localparam int SLOT_W  = 8;
  localparam int COUNT_W = 16;
  localparam int TE_W    = 9;
  localparam int HASH_W  = 32;

  // Defaults for the top-level parameters.
  localparam int TABLE_DEPTH_DEF     = 256;
  localparam int VALUE_WIDTH_DEF     = 32;
  localparam int MAX_NAME_LENGTH_DEF = 32;

  localparam logic [HASH_W-1:0]  FNV_BASIS  = 32'd2166136261;
  localparam logic [HASH_W-1:0]  FNV_FACTOR = 32'd16777619;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = 16'hFFFF;
  localparam logic [TE_W-1:0]    TE_RESET   = 9'd256;

  typedef enum logic [CMD_W-1:0] {
    CMD_CREATE = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_LOOKUP = 2'd2
  } fhbt_cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_DIV,
    ST_MEM,
    ST_RESP
  } fhbt_state_e;

  typedef struct packed {
    logic fold;       // fold the byte of an add or lookup item
    logic finish;     // the folded item carries the last byte of its name
    logic clr_start;  // create: reset counters and start the clearing sweep
    logic clr_step;   // clear one table entry
    logic div_step;   // one step of the slot division
    logic mem_en;     // table access for the finished item
  } fhbt_ctrl_t;

  typedef struct packed {
    logic created;
    logic clr_last;
    logic div_last;
  } fhbt_sts_t;

endpackage

### rtl/core/fnv1a_hashed_bucket_table_unit.sv
// Top level of the hashed bucket table unit: controller and datapath.
// Depends on fhbt_pkg, fhbt_ctrl and fhbt_datapath.
//
// An item is taken when start_i is high and busy_o is low. A name byte that
// is not the last of its name leaves busy_o low, so bytes can follow back to
// back. The last byte of an add or lookup keeps busy_o high until its result
// has been shown: the 32-bit hash is reduced by a bit-serial divider, then the
// table is accessed and the result is shown. On a table that has not been
// created the last byte goes straight to its result, with no division and no
// table access. A create sweeps the table one entry a cycle and then shows its
// result; the clearing is done by that sweep only. Each result is held for
// exactly one cycle with done_o high, and the receiver cannot stall it.
// table_entries_i is written whenever table_entries_we_i is high and should
// only change while idle.
module fnv1a_hashed_bucket_table_unit #(
  parameter int TABLE_DEPTH     = fhbt_pkg::TABLE_DEPTH_DEF,
  parameter int VALUE_WIDTH     = fhbt_pkg::VALUE_WIDTH_DEF,
  parameter int MAX_NAME_LENGTH = fhbt_pkg::MAX_NAME_LENGTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [fhbt_pkg::CMD_W-1:0]   command_i,
  input  logic [fhbt_pkg::BYTE_W-1:0]  name_byte_i,
  input  logic                         name_last_i,
  input  logic [fhbt_pkg::NV_W-1:0]    new_value_i,
  input  logic                         table_entries_we_i,
  input  logic [fhbt_pkg::TE_W-1:0]    table_entries_i,
  output logic                         done_o,
  output logic                         status_o,
  output logic [fhbt_pkg::FOUND_W-1:0] found_value_o,
  output logic [fhbt_pkg::SLOT_W-1:0]  slot_index_o,
  output logic [fhbt_pkg::COUNT_W-1:0] entry_count_o
);
  import fhbt_pkg::*;

  fhbt_ctrl_t ctrl;
  fhbt_sts_t  sts;

  fhbt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .command_i   (command_i),
    .name_last_i (name_last_i),
    .sts_i       (sts),
    .ctrl_o      (ctrl),
    .busy_o      (busy_o),
    .done_o      (done_o)
  );

  fhbt_datapath #(
    .TABLE_DEPTH     (TABLE_DEPTH),
    .VALUE_WIDTH     (VALUE_WIDTH),
    .MAX_NAME_LENGTH (MAX_NAME_LENGTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .sts_o         (sts),
    .command_i     (command_i),
    .name_byte_i   (name_byte_i),
    .new_value_i   (new_value_i),
    .te_we_i       (table_entries_we_i),
    .te_i          (table_entries_i),
    .status_o      (status_o),
    .found_value_o (found_value_o),
    .slot_index_o  (slot_index_o),
    .entry_count_o (entry_count_o)
  );

endmodule

### rtl/core/fhbt_ctrl.sv
// Sequencing controller of the hashed bucket table unit.
// Depends on fhbt_pkg for the state type, the command codes and the
// control and status structs.
module fhbt_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [fhbt_pkg::CMD_W-1:0] command_i,
  input  logic                       name_last_i,
  input  fhbt_pkg::fhbt_sts_t        sts_i,
  output fhbt_pkg::fhbt_ctrl_t       ctrl_o,
  output logic                       busy_o,
  output logic                       done_o
);
  import fhbt_pkg::*;

  fhbt_state_e state_q, state_d;
  logic        accept;
  logic        is_name_cmd;

  assign accept      = start_i && (state_q == ST_IDLE);
  assign is_name_cmd = (command_i == CMD_ADD) || (command_i == CMD_LOOKUP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (command_i == CMD_CREATE)) begin
          state_d = ST_CLEAR;
        end else if (accept && is_name_cmd && name_last_i) begin
          // An uncreated table answers at once, without a table access.
          state_d = sts_i.created ? ST_DIV : ST_RESP;
        end
      end
      ST_CLEAR: begin
        if (sts_i.clr_last) begin
          state_d = ST_RESP;
        end
      end
      ST_DIV: begin
        if (sts_i.div_last) begin
          state_d = ST_MEM;
        end
      end
      ST_MEM:  state_d = ST_RESP;
      ST_RESP: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o           = '0;
    ctrl_o.fold      = accept && is_name_cmd;
    ctrl_o.finish    = accept && is_name_cmd && name_last_i;
    ctrl_o.clr_start = accept && (command_i == CMD_CREATE);
    ctrl_o.clr_step  = (state_q == ST_CLEAR);
    ctrl_o.div_step  = (state_q == ST_DIV);
    ctrl_o.mem_en    = (state_q == ST_MEM);
    busy_o           = (state_q != ST_IDLE);
    done_o           = (state_q == ST_RESP);
  end

  a_mem_then_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MEM) |=> done_o)
    else $error("table access not followed by a result");

  a_created_goes_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_o.finish && sts_i.created) |=> (state_q == ST_DIV))
    else $error("finished name on a created table did not start the division");

  a_div_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DIV) && !sts_i.div_last) |=> (state_q == ST_DIV))
    else $error("division left before its last step");

  a_done_then_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_o)
    else $error("unit still busy after delivering a result");

  a_create_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_CLEAR) && sts_i.clr_last) |=> done_o)
    else $error("clearing sweep ended without a result");

endmodule

### rtl/core/fhbt_datapath.sv
// Datapath of the hashed bucket table unit: FNV-1a fold, bit-serial slot
// division, the bucket memory and the result registers.
// Depends on fhbt_pkg for widths, constants and the control structs.
module fhbt_datapath #(
  parameter int TABLE_DEPTH     = fhbt_pkg::TABLE_DEPTH_DEF,
  parameter int VALUE_WIDTH     = fhbt_pkg::VALUE_WIDTH_DEF,
  parameter int MAX_NAME_LENGTH = fhbt_pkg::MAX_NAME_LENGTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  fhbt_pkg::fhbt_ctrl_t         ctrl_i,
  output fhbt_pkg::fhbt_sts_t          sts_o,
  input  logic [fhbt_pkg::CMD_W-1:0]   command_i,
  input  logic [fhbt_pkg::BYTE_W-1:0]  name_byte_i,
  input  logic [fhbt_pkg::NV_W-1:0]    new_value_i,
  input  logic                         te_we_i,
  input  logic [fhbt_pkg::TE_W-1:0]    te_i,
  output logic                         status_o,
  output logic [fhbt_pkg::FOUND_W-1:0] found_value_o,
  output logic [fhbt_pkg::SLOT_W-1:0]  slot_index_o,
  output logic [fhbt_pkg::COUNT_W-1:0] entry_count_o
);
  import fhbt_pkg::*;

  localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int DW  = $clog2(TABLE_DEPTH + 1);
  localparam int CW  = (DW > TE_W) ? DW : TE_W;
  localparam int BCW = $clog2(MAX_NAME_LENGTH + 1);
  localparam int SXW = AW + SLOT_W;

  // Name accumulator and table bookkeeping.
  logic [HASH_W-1:0]  hash_q;
  logic [BCW-1:0]     byte_cnt_q;
  logic               ended_q;
  logic               created_q;
  logic [COUNT_W-1:0] count_q;
  logic [TE_W-1:0]    te_q;
  logic [AW-1:0]      clr_addr_q;
  logic [4:0]         div_cnt_q;

  // Item registers, no reset needed.
  logic [HASH_W-1:0]      dividend_q;
  logic [DW-1:0]          divisor_q;
  logic [DW-1:0]          rem_q;
  logic [CMD_W-1:0]       op_q;
  logic                   status_q;
  logic [VALUE_WIDTH-1:0] value_q;
  logic [VALUE_WIDTH-1:0] rd_q;
  logic [VALUE_WIDTH-1:0] mem_q [TABLE_DEPTH];

  logic [HASH_W-1:0] hash_mix;
  logic [HASH_W-1:0] hash_mult;
  logic [HASH_W-1:0] hash_next;
  logic              byte_takes;
  logic [CW-1:0]     te_ext;
  logic [DW-1:0]     divisor_sel;
  logic [DW:0]       trial;
  logic [DW:0]       divisor_ext;
  logic [AW-1:0]     slot;
  logic [SXW-1:0]    slot_ext;
  logic [63:0]       nv_ext;
  logic [63:0]       rd_ext;
  logic              slot_ok;

  // A byte is hashed unless the name has ended, it ends the name, or the
  // length limit has been reached.
  assign byte_takes = !ended_q && (name_byte_i != '0) &&
                      (byte_cnt_q < BCW'(MAX_NAME_LENGTH));
  assign hash_mix   = hash_q ^ HASH_W'(name_byte_i);
  assign hash_mult  = hash_mix * FNV_FACTOR;
  assign hash_next  = byte_takes ? hash_mult : hash_q;

  // Clamp the entry count into one to the table depth.
  assign te_ext = CW'(te_q);
  always_comb begin
    priority if (te_q == '0) begin
      divisor_sel = DW'(1);
    end else if (te_ext > CW'(TABLE_DEPTH)) begin
      divisor_sel = DW'(TABLE_DEPTH);
    end else begin
      divisor_sel = te_ext[DW-1:0];
    end
  end

  // Restoring division, one quotient bit a cycle; only the remainder is kept.
  assign trial       = {rem_q, dividend_q[HASH_W-1]};
  assign divisor_ext = {1'b0, divisor_q};
  assign slot        = rem_q[AW-1:0];

  assign nv_ext = 64'(new_value_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q     <= FNV_BASIS;
      byte_cnt_q <= '0;
      ended_q    <= 1'b0;
      created_q  <= 1'b0;
      count_q    <= '0;
      te_q       <= TE_RESET;
      clr_addr_q <= '0;
      div_cnt_q  <= '0;
    end else begin
      if (te_we_i) begin
        te_q <= te_i;
      end
      if (ctrl_i.clr_start || ctrl_i.finish) begin
        hash_q     <= FNV_BASIS;
        byte_cnt_q <= '0;
        ended_q    <= 1'b0;
      end else if (ctrl_i.fold) begin
        hash_q <= hash_next;
        if (!ended_q && (name_byte_i == '0)) begin
          ended_q <= 1'b1;
        end
        if (byte_takes) begin
          byte_cnt_q <= byte_cnt_q + BCW'(1);
        end
      end
      if (ctrl_i.clr_start) begin
        created_q  <= 1'b1;
        count_q    <= '0;
        clr_addr_q <= '0;
      end else if (ctrl_i.clr_step) begin
        clr_addr_q <= clr_addr_q + AW'(1);
      end
      if (ctrl_i.finish) begin
        div_cnt_q <= '0;
      end else if (ctrl_i.div_step) begin
        div_cnt_q <= div_cnt_q + 5'd1;
      end
      if (ctrl_i.mem_en && (op_q == CMD_ADD) && (count_q != COUNT_MAX)) begin
        count_q <= count_q + COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.finish) begin
      dividend_q <= hash_next;
      divisor_q  <= divisor_sel;
      rem_q      <= '0;
      op_q       <= command_i;
      status_q   <= !created_q;
      value_q    <= nv_ext[VALUE_WIDTH-1:0];
    end else if (ctrl_i.clr_start) begin
      op_q     <= CMD_CREATE;
      status_q <= 1'b0;
    end else if (ctrl_i.div_step) begin
      dividend_q <= {dividend_q[HASH_W-2:0], 1'b0};
      if (trial >= divisor_ext) begin
        rem_q <= DW'(trial - divisor_ext);
      end else begin
        rem_q <= trial[DW-1:0];
      end
    end
  end

  // Bucket memory: one write port shared by the clearing sweep and adds,
  // one registered read port.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.clr_step) begin
      mem_q[clr_addr_q] <= '0;
    end else if (ctrl_i.mem_en && (op_q == CMD_ADD)) begin
      mem_q[slot] <= value_q;
    end
    if (ctrl_i.mem_en) begin
      rd_q <= mem_q[slot];
    end
  end

  assign sts_o.created  = created_q;
  assign sts_o.clr_last = (clr_addr_q == AW'(TABLE_DEPTH - 1));
  assign sts_o.div_last = (div_cnt_q == 5'd31);

  // Results of a create or of a refused command carry no slot and no word.
  assign slot_ok       = (op_q != CMD_CREATE) && !status_q;
  assign rd_ext        = 64'(rd_q);
  assign slot_ext      = SXW'(slot);
  assign status_o      = status_q;
  assign found_value_o = (slot_ok && (op_q == CMD_LOOKUP)) ? rd_ext[FOUND_W-1:0] : '0;
  assign slot_index_o  = slot_ok ? slot_ext[SLOT_W-1:0] : '0;
  assign entry_count_o = count_q;

endmodule

### tb/fnv1a_hashed_bucket_table_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for fnv1a_hashed_bucket_table_unit.
// Drives create, add and lookup items and checks every result strobe against an
// in-bench model of the table or a pinned result. Depends on fhbt_pkg and the unit.
module fnv1a_hashed_bucket_table_unit_tb;
  import fhbt_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES     = 40;
  localparam int WATCHDOG_LIMIT   = 5000;
  localparam int RANDOM_ITEMS     = 640;
  localparam int FINAL_NAMES      = 8;

  typedef struct packed {
    logic               status;
    logic [FOUND_W-1:0] found;
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] count;
  } bucket_result_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [BYTE_W-1:0] nbyte;
    logic              last;
    logic [NV_W-1:0]   nv;
    logic              pinned;
    bucket_result_t    pin;
  } stim_row_t;

  logic                clk_i              = 1'b0;
  logic                rst_ni             = 1'b0;
  logic                start_i            = 1'b0;
  logic [CMD_W-1:0]    command_i          = '0;
  logic [BYTE_W-1:0]   name_byte_i        = '0;
  logic                name_last_i        = 1'b0;
  logic [NV_W-1:0]     new_value_i        = '0;
  logic                table_entries_we_i = 1'b0;
  logic [TE_W-1:0]     table_entries_i    = '0;
  logic                busy_o;
  logic                done_o;
  logic                status_o;
  logic [FOUND_W-1:0]  found_value_o;
  logic [SLOT_W-1:0]   slot_index_o;
  logic [COUNT_W-1:0]  entry_count_o;

  // A pinned expectation travels with its item, so it is driven like one.
  logic                pin_valid  = 1'b0;
  bucket_result_t      pin_result = '0;

  fnv1a_hashed_bucket_table_unit uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .command_i          (command_i),
    .name_byte_i        (name_byte_i),
    .name_last_i        (name_last_i),
    .new_value_i        (new_value_i),
    .table_entries_we_i (table_entries_we_i),
    .table_entries_i    (table_entries_i),
    .done_o             (done_o),
    .status_o           (status_o),
    .found_value_o      (found_value_o),
    .slot_index_o       (slot_index_o),
    .entry_count_o      (entry_count_o)
  );

  always #1 clk_i = ~clk_i;

  // Model state of the table.
  logic [HASH_W-1:0]  hash_acc;
  int unsigned        name_len;
  bit                 name_done;
  bit                 tbl_made;
  logic [COUNT_W-1:0] adds_made;
  logic [NV_W-1:0]    bucket_mem [TABLE_DEPTH_DEF];
  logic [TE_W-1:0]    entries_reg;

  bucket_result_t     pending_results[$];
  stim_row_t          stim_rows[$];
  logic [BYTE_W-1:0]  last_added[$];
  int                 error_count     = 0;
  int                 results_checked = 0;
  int                 items_sent      = 0;
  int                 idle_cycles     = 0;
  bit                 gaps_on         = 1'b1;

  function automatic void clear_name_hash();
    hash_acc  = FNV_BASIS;
    name_len  = 0;
    name_done = 1'b0;
  endfunction

  function automatic bit predict_bucket(input logic [CMD_W-1:0] cmd,
                                        input logic [BYTE_W-1:0] b,
                                        input logic last,
                                        input logic [NV_W-1:0] nv,
                                        output bucket_result_t r);
    int unsigned div;
    int unsigned slot;
    r = '0;
    if (cmd == CMD_UNUSED) return 1'b0;
    if (cmd == CMD_CREATE) begin
      foreach (bucket_mem[i]) bucket_mem[i] = '0;
      adds_made = '0;
      tbl_made  = 1'b1;
      clear_name_hash();
      return 1'b1;
    end
    if (!name_done) begin
      if (b == 8'd0) begin
        name_done = 1'b1;
      end else if (name_len < MAX_NAME_LENGTH_DEF) begin
        hash_acc = (hash_acc ^ {24'd0, b}) * FNV_FACTOR;
        name_len++;
      end
    end
    if (!last) return 1'b0;
    if (!tbl_made) begin
      clear_name_hash();
      r.status = 1'b1;
      r.count  = adds_made;
      return 1'b1;
    end
    div = entries_reg;
    if (div == 0) div = 1;
    if (div > TABLE_DEPTH_DEF) div = TABLE_DEPTH_DEF;
    slot = hash_acc % div;
    clear_name_hash();
    if (cmd == CMD_ADD) begin
      bucket_mem[slot] = nv;
      if (adds_made != COUNT_MAX) adds_made++;
    end else begin
      r.found = bucket_mem[slot];
    end
    r.slot  = slot[SLOT_W-1:0];
    r.count = adds_made;
    return 1'b1;
  endfunction

  initial begin
    clear_name_hash();
    tbl_made    = 1'b0;
    adds_made   = '0;
    entries_reg = TE_RESET;
    foreach (bucket_mem[i]) bucket_mem[i] = '0;
  end

  // Everything here samples values from before the edge, since all stimulus
  // is driven with nonblocking assignments.
  always @(posedge clk_i) begin
    bucket_result_t got;
    bucket_result_t want;
    bucket_result_t pred;
    bit             busy_edge;
    if (rst_ni) begin
      busy_edge = 1'b0;
      if (done_o) begin
        busy_edge = 1'b1;
        got = {status_o, found_value_o, slot_index_o, entry_count_o};
        if (pending_results.size() == 0) begin
          $error("result with nothing expected: status %0h found %0h slot %0h count %0h",
                 got.status, got.found, got.slot, got.count);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          if (got.status !== want.status) begin
            $error("status: expected %0h, got %0h", want.status, got.status);
            error_count++;
          end
          if (got.found !== want.found) begin
            $error("found_value: expected %0h, got %0h", want.found, got.found);
            error_count++;
          end
          if (got.slot !== want.slot) begin
            $error("slot_index: expected %0h, got %0h", want.slot, got.slot);
            error_count++;
          end
          if (got.count !== want.count) begin
            $error("entry_count: expected %0h, got %0h", want.count, got.count);
            error_count++;
          end
        end
      end
      if (table_entries_we_i) entries_reg = table_entries_i;
      if (start_i && !busy_o) begin
        busy_edge = 1'b1;
        if (predict_bucket(command_i, name_byte_i, name_last_i, new_value_i, pred))
          pending_results.push_back(pin_valid ? pin_result : pred);
      end
      idle_cycles = busy_edge ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: nothing accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Called at a rising edge; unless a random gap drops start_i, returns at the
  // accepting edge with start_i high, so the next item keeps it without a glitch.
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] b,
                           input logic last, input logic [NV_W-1:0] nv,
                           input logic pinned, input bucket_result_t pin);
    start_i     <= 1'b1;
    command_i   <= cmd;
    name_byte_i <= b;
    name_last_i <= last;
    new_value_i <= nv;
    pin_valid   <= pinned;
    pin_result  <= pin;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    if (cmd != CMD_UNUSED) items_sent++;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    // A trailing name byte gives no result, so the queue above does not wait for it.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_entries(input logic [TE_W-1:0] value);
    wait_drained();
    table_entries_we_i <= 1'b1;
    table_entries_i    <= value;
    @(posedge clk_i);
    table_entries_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic add_row(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] b,
                         input logic last, input logic [NV_W-1:0] nv,
                         input logic pinned, input logic status,
                         input logic [COUNT_W-1:0] count);
    stim_row_t row;
    row           = '0;
    row.cmd       = cmd;
    row.nbyte     = b;
    row.last      = last;
    row.nv        = nv;
    row.pinned    = pinned;
    row.pin.status = status;
    row.pin.count  = count;
    stim_rows.push_back(row);
  endtask

  function automatic logic [BYTE_W-1:0] rand_name_byte();
    return ($urandom_range(0, 11) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
  endfunction

  function automatic logic [NV_W-1:0] rand_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // One name of random length; a replayed lookup reuses the last added name
  // so that lookups hit slots that were actually written.
  task automatic send_name(input logic [CMD_W-1:0] final_cmd, input bit replay);
    logic [BYTE_W-1:0] name_q[$];
    logic [CMD_W-1:0]  c;
    int                len;
    bit                mixed;
    if (replay && last_added.size() != 0) begin
      name_q = last_added;
    end else begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 6);
      repeat (len) name_q.push_back(rand_name_byte());
    end
    if (final_cmd == CMD_ADD) last_added = name_q;
    mixed = ($urandom_range(0, 7) == 0);
    foreach (name_q[i]) begin
      if (i == name_q.size() - 1) c = final_cmd;
      else if (mixed)             c = $urandom_range(0, 1) ? CMD_ADD : CMD_LOOKUP;
      else                        c = final_cmd;
      send_item(c, name_q[i], i == name_q.size() - 1, rand_word(), 1'b0, '0);
    end
  endtask

  initial begin
    logic [TE_W-1:0] entry_settings[8];
    int              phase_end;
    int              pick;

    entry_settings = '{9'd256, 9'd1, 9'd0, 9'd257, 9'd511, 9'd2, 9'd0, 9'd200};
    entry_settings[6] = TE_W'($urandom_range(3, 255));

    // Uncreated table first, then the plain operations and the name rules.
    add_row(CMD_ADD,    8'h61, 1'b1, 32'hA5A5A5A5, 1'b1, 1'b1, 16'd0);
    add_row(CMD_LOOKUP, 8'hFF, 1'b1, 32'h0,        1'b1, 1'b1, 16'd0);
    add_row(CMD_LOOKUP, 8'h00, 1'b0, 32'h0,        1'b0, 1'b0, 16'd0);
    add_row(CMD_ADD,    8'h80, 1'b1, 32'hFFFFFFFF, 1'b1, 1'b1, 16'd0);
    add_row(CMD_UNUSED, 8'hFF, 1'b1, 32'hFFFFFFFF, 1'b0, 1'b0, 16'd0);
    add_row(CMD_CREATE, 8'h55, 1'b0, 32'h0,        1'b1, 1'b0, 16'd0);
    add_row(CMD_ADD,    8'h01, 1'b0, 32'h0,        1'b0, 1'b0, 16'd0);
    add_row(CMD_ADD,    8'hFF, 1'b0, 32'h0,        1'b0, 1'b0, 16'd0);
    add_row(CMD_ADD,    8'h80, 1'b1, 32'hFFFFFFFF, 1'b0, 1'b0, 16'd0);
    add_row(CMD_LOOKUP, 8'h01, 1'b0, 32'h0,        1'b0, 1'b0, 16'd0);
    add_row(CMD_LOOKUP, 8'hFF, 1'b0, 32'h0,        1'b0, 1'b0, 16'd0);
    add_row(CMD_LOOKUP, 8'h80, 1'b1, 32'h0,        1'b0, 1'b0, 16'd0);
    add_row(CMD_LOOKUP, 8'h78, 1'b0, 32'h0,        1'b0, 1'b0, 16'd0);
    add_row(CMD_ADD,    8'h79, 1'b1, 32'h00000000, 1'b0, 1'b0, 16'd0);
    add_row(CMD_ADD,    8'h61, 1'b0, 32'h0,        1'b0, 1'b0, 16'd0);
    add_row(CMD_ADD,    8'h00, 1'b0, 32'h0,        1'b0, 1'b0, 16'd0);
    add_row(CMD_ADD,    8'h62, 1'b1, 32'h12345678, 1'b0, 1'b0, 16'd0);
    add_row(CMD_LOOKUP, 8'h00, 1'b1, 32'h0,        1'b0, 1'b0, 16'd0);
    add_row(CMD_ADD,    8'h71, 1'b0, 32'h0,        1'b0, 1'b0, 16'd0);
    add_row(CMD_CREATE, 8'h00, 1'b1, 32'hFFFFFFFF, 1'b1, 1'b0, 16'd0);
    add_row(CMD_LOOKUP, 8'h71, 1'b1, 32'h0,        1'b0, 1'b0, 16'd0);
    add_row(CMD_UNUSED, 8'h00, 1'b0, 32'h0,        1'b0, 1'b0, 16'd0);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_rows[i])
      send_item(stim_rows[i].cmd, stim_rows[i].nbyte, stim_rows[i].last, stim_rows[i].nv,
                stim_rows[i].pinned, stim_rows[i].pin);

    // Random part, one phase per table size, each written while idle.
    foreach (entry_settings[p]) begin
      write_entries(entry_settings[p]);
      gaps_on   = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 1) == 0) send_item(CMD_CREATE, rand_name_byte(), 1'b0, '0,
                                               1'b0, '0);
      phase_end = items_sent + RANDOM_ITEMS / 8;
      while (items_sent < phase_end) begin
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
          send_item(CMD_CREATE, rand_name_byte(), 1'($urandom), rand_word(), 1'b0, '0);
        end else if (pick < 8) begin
          send_item(CMD_UNUSED, 8'($urandom), 1'($urandom), rand_word(), 1'b0, '0);
        end else if (pick < 12) begin
          // A broken name: bytes without a last marker run into the next name.
          repeat ($urandom_range(1, 3))
            send_item($urandom_range(0, 1) ? CMD_ADD : CMD_LOOKUP, rand_name_byte(), 1'b0,
                      rand_word(), 1'b0, '0);
        end else if (pick < 14) begin
          wait_drained();
        end else if (pick < 57) begin
          send_name(CMD_ADD, 1'b0);
        end else begin
          send_name(CMD_LOOKUP, $urandom_range(0, 9) < 4);
        end
      end
    end

    // Adds and replayed lookups back to back, with no idling to the end of the run.
    write_entries(TE_RESET);
    gaps_on = 1'b0;
    send_item(CMD_CREATE, 8'h00, 1'b0, '0, 1'b0, '0);
    repeat (FINAL_NAMES) begin
      send_name(CMD_ADD, 1'b0);
      send_name(CMD_LOOKUP, 1'b1);
    end

    wait_drained();
    $display("Sent %0d items over %0d table sizes; %0d results checked.",
             items_sent, 8, results_checked);
    $display("Covered an uncreated table, name limits, mixed commands and size clamping.");
    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
